// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// KADT_ASSERT checks that a property holds; KADT_NEVER checks that a condition never holds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define KADT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define KADT_NEVER(lbl, clk, rstn, cond) \
  `KADT_ASSERT(lbl, clk, rstn, !(cond))
`else
`define KADT_ASSERT(lbl, clk, rstn, prop)
`define KADT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== rtl/kadt_pkg.sv =====
`timescale 1ns / 1ps

package kadt_pkg;

  // Default table depth
  localparam int unsigned KadtCapacity = 16;

  // Command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_ACCUM      = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] key;
    logic [15:0] count_a;
    logic [15:0] count_b;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_key;
    logic [15:0] out_count_a;
    logic [15:0] out_count_b;
    logic        merged;
    logic [4:0]  fill;
  } out_rsp_t;

  // One table slot as stored in memory
  typedef struct packed {
    logic [15:0] key;
    logic [15:0] count_a;
    logic [15:0] count_b;
  } entry_t;

  // Saturating 16-bit add
  function automatic logic [15:0] sat_add16(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

// ===== rtl/kadt_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port
module kadt_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/keyed_accumulate_deque_table_core.sv =====
// Keyed accumulate deque table.
// Requests enter on in_valid_i/in_stall_o with payload in_req_i; each request gives one
// response on out_valid_o/out_stall_i with payload out_rsp_o.
// Entries live in a ring buffer in one RAM (head pointer plus fill count), so front and
// back inserts and removes never move data.
// Path from request to response valid:
//   inserts, refused or ignored requests: result in res_q (S_RESP), then output register
//   removes: RAM read, entry taken in S_POP, then S_RESP and the output register
//   accumulate: search in S_SEARCH, then S_RESP; the key search reads one entry per cycle
//   through the single RAM read port and stops at the first match.
// One request is worked on at a time: in_stall_o is high from acceptance until its
// response sits in the output register. A new request is taken while that response
// still waits on a stalled receiver; the next response then waits in the block.
// Reset empties the table at once (fill count and head cleared); RAM contents are
// never read before being written, so no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keyed_accumulate_deque_table_core
  import kadt_pkg::*;
#(
  parameter int unsigned CAPACITY = KadtCapacity
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_POP    = 4'b0010,
    S_SEARCH = 4'b0100,
    S_RESP   = 4'b1000
  } state_e;

  state_e         st_q, st_d;
  logic [PW-1:0]  hd_q, hd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  entry_t         item_q, item_d;
  logic [PW-1:0]  ptr_q, ptr_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic           pv_q, pv_d;
  logic [PW-1:0]  pa_q, pa_d;
  out_rsp_t       res_q, res_d;
  logic           out_valid_q, out_valid_d;
  out_rsp_t       out_q, out_d;

  logic           wr_en, rd_en, fill_upd;
  logic [PW-1:0]  wr_addr, rd_addr;
  entry_t         wr_data, rd_data;
  logic [$bits(entry_t)-1:0] rd_raw;

  logic           accept, full, empty, hit;
  logic [CW:0]    tsum, lsum;
  logic [PW-1:0]  tail, last, hd_inc, hd_dec, ptr_inc;

  // Ring pointer arithmetic
  assign full   = (cnt_q == CW'(CAPACITY));
  assign empty  = (cnt_q == '0);
  assign tsum   = (CW+1)'(hd_q) + (CW+1)'(cnt_q);
  assign lsum   = tsum - (CW+1)'(1);
  assign tail   = (tsum >= (CW+1)'(CAPACITY)) ? PW'(tsum - (CW+1)'(CAPACITY)) : PW'(tsum);
  assign last   = (lsum >= (CW+1)'(CAPACITY)) ? PW'(lsum - (CW+1)'(CAPACITY)) : PW'(lsum);
  assign hd_inc = (hd_q == PW'(CAPACITY - 1)) ? '0 : hd_q + PW'(1);
  assign hd_dec = (hd_q == '0) ? PW'(CAPACITY - 1) : hd_q - PW'(1);
  assign ptr_inc = (ptr_q == PW'(CAPACITY - 1)) ? '0 : ptr_q + PW'(1);

  assign accept = in_valid_i && (st_q == S_IDLE);
  assign rd_data = entry_t'(rd_raw);
  assign hit    = pv_q && (rd_data.key == item_q.key);

  // Command sequencer
  always_comb begin
    st_d        = st_q;
    hd_d        = hd_q;
    cnt_d       = cnt_q;
    item_d      = item_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    pv_d        = 1'b0;
    pa_d        = pa_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_addr     = tail;
    wr_data     = item_q;
    rd_en       = 1'b0;
    rd_addr     = hd_q;
    fill_upd    = 1'b0;

    case (st_q)
      S_IDLE: begin
        if (accept) begin
          item_d   = '{key: in_req_i.key, count_a: in_req_i.count_a,
                       count_b: in_req_i.count_b};
          res_d    = '0;
          fill_upd = 1'b1;
          st_d     = S_RESP;
          case (in_req_i.cmd)
            CMD_PUSH_FRONT: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = hd_dec;
                wr_data = item_d;
                hd_d    = hd_dec;
                cnt_d   = cnt_q + CW'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = tail;
                wr_data = item_d;
                cnt_d   = cnt_q + CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                res_d.status = STAT_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = hd_q;
                hd_d    = hd_inc;
                cnt_d   = cnt_q - CW'(1);
                st_d    = S_POP;
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                res_d.status = STAT_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = last;
                cnt_d   = cnt_q - CW'(1);
                st_d    = S_POP;
              end
            end
            CMD_ACCUM: begin
              fill_upd = 1'b0;
              ptr_d    = hd_q;
              idx_d    = '0;
              st_d     = S_SEARCH;
            end
            default: ;
          endcase
        end
      end

      // Removed entry arrives from the RAM
      S_POP: begin
        res_d.out_key     = rd_data.key;
        res_d.out_count_a = rd_data.count_a;
        res_d.out_count_b = rd_data.count_b;
        st_d              = S_RESP;
      end

      // Key search: one read issued per cycle, compared in the following cycle
      S_SEARCH: begin
        if (hit) begin
          wr_en           = 1'b1;
          wr_addr         = pa_q;
          wr_data.key     = rd_data.key;
          wr_data.count_a = sat_add16(rd_data.count_a, item_q.count_a);
          wr_data.count_b = sat_add16(rd_data.count_b, item_q.count_b);
          res_d.merged    = 1'b1;
          fill_upd        = 1'b1;
          st_d            = S_RESP;
        end else if (idx_q == cnt_q) begin
          if (full) begin
            res_d.status = STAT_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = tail;
            cnt_d   = cnt_q + CW'(1);
          end
          fill_upd = 1'b1;
          st_d     = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_q;
          ptr_d   = ptr_inc;
          idx_d   = idx_q + CW'(1);
          pv_d    = 1'b1;
          pa_d    = ptr_q;
        end
      end

      // Hand the response to the output register once it is free
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          st_d        = S_IDLE;
        end
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase

    if (fill_upd) begin
      res_d.fill = 5'(cnt_d);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      hd_q        <= '0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      hd_q        <= hd_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and search registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    ptr_q  <= ptr_d;
    idx_q  <= idx_d;
    pa_q   <= pa_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  kadt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_raw)
  );

  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Checks
  `KADT_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(CAPACITY))
  `KADT_NEVER(a_rd_wr_excl, clk_i, rst_ni, wr_en && rd_en)
  `KADT_ASSERT(a_wr_state, clk_i, rst_ni, wr_en |-> (st_q == S_IDLE || st_q == S_SEARCH))
  `KADT_NEVER(a_idx_bound, clk_i, rst_ni, st_q == S_SEARCH && idx_q > cnt_q)
  `KADT_ASSERT(a_pop_read, clk_i, rst_ni, st_q == S_POP |-> $past(rd_en))

endmodule
